>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Codes, reset values and the command record shared by the console core.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Item kinds as they arrive on the request channel.
   localparam logic [2:0] MODE_STREAM = 3'd0;
   localparam logic [2:0] MODE_PLACE  = 3'd1;
   localparam logic [2:0] MODE_MOVE   = 3'd2;
   localparam logic [2:0] MODE_CLEAR  = 3'd3;
   localparam logic [2:0] MODE_READ   = 3'd4;

   // Special character codes in stream mode.
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NONE    = 8'h00;

   // Configuration register indexes.
   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_ROWS    = 1'b1;

   // Register values after reset.
   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET    = 7'd25;

   // What the back end has to do for one item.
   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_CHAR,
      KIND_NEWLINE,
      KIND_PLACE,
      KIND_MOVE,
      KIND_CLEAR,
      KIND_READ
   } kind_type;

   // One classified item as it sits in the command queue.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_byte;
      logic [6:0]  column;
      logic [5:0]  row;
      logic        out_of_range;
   } cmd_type;

   // Handshake between the command queue and its neighbors.
   typedef struct packed {
      logic full;
      logic head_valid;
   } queue_status_type;

endpackage

>>> rtl/core/tcw_front.sv
// ----------------------------------------------------------------------------
// Text console front end
// Accepts request beats, decodes the mode and checks positions against the
// active screen size, and hands a command record to the queue.
// ----------------------------------------------------------------------------
module tcw_front
   import tcw_pkg::*;
#(
   parameter int ACOL_W = 8,
   parameter int AROW_W = 7
) (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [2:0]        req_tuser,   // [2:0] mode
   input  logic [23:0]       req_tdata,   // [7:0] char_byte, [14:8] column, [20:15] row
   input  logic [ACOL_W-1:0] active_cols,
   input  logic [AROW_W-1:0] active_rows,
   input  queue_status_type  queue_status,
   output logic              push,
   output cmd_type           push_cmd
);

   logic [7:0] char_byte;
   logic [6:0] column;
   logic [5:0] row;
   logic       col_over;
   logic       row_over;

   assign char_byte = req_tdata[7:0];
   assign column    = req_tdata[14:8];
   assign row       = req_tdata[20:15];

   // A beat is taken whenever the queue has room.
   assign req_tready = !queue_status.full;
   assign push       = req_tvalid && !queue_status.full;

   assign col_over = 32'(column) >= 32'(active_cols);
   assign row_over = 32'(row) >= 32'(active_rows);

   // Classify the item and settle everything that depends only on the item.
   always_comb begin
      push_cmd              = '0;
      push_cmd.char_byte    = char_byte;
      push_cmd.column       = column;
      push_cmd.row          = row;
      push_cmd.kind         = KIND_NOP;
      case (req_tuser)
         MODE_STREAM: begin
            if (char_byte == CHAR_NEWLINE) begin
               push_cmd.kind = KIND_NEWLINE;
            end else if (char_byte != CHAR_NONE) begin
               push_cmd.kind = KIND_CHAR;
            end
         end
         MODE_PLACE: begin
            push_cmd.kind         = KIND_PLACE;
            push_cmd.out_of_range = col_over || row_over;
         end
         MODE_MOVE: begin
            // The target is clamped to the last active column and row.
            push_cmd.kind = KIND_MOVE;
            if (col_over) begin
               push_cmd.column = 7'(active_cols - ACOL_W'(1));
            end
            if (row_over) begin
               push_cmd.row = 6'(active_rows - AROW_W'(1));
            end
         end
         MODE_CLEAR: begin
            push_cmd.kind = KIND_CLEAR;
         end
         MODE_READ: begin
            push_cmd.kind         = KIND_READ;
            push_cmd.out_of_range = col_over || row_over;
         end
         default: begin
            push_cmd.kind = KIND_NOP;
         end
      endcase
   end

endmodule

>>> rtl/core/tcw_cmd_queue.sv
// ----------------------------------------------------------------------------
// Text console command queue
// Two-entry queue that lets the front end keep accepting while the back end
// sweeps a row or waits on the output.
// ----------------------------------------------------------------------------
module tcw_cmd_queue
   import tcw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output queue_status_type queue_status,
   output cmd_type          head_cmd
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign queue_status.full       = count_ff == 2'd2;
   assign queue_status.head_valid = count_ff != 2'd0;
   assign head_cmd                = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/tcw_back.sv
// ----------------------------------------------------------------------------
// Text console back end
// Owns the cell memory, the cursor, the top-row offset and the row valid
// bits, carries out one command at a time and drives the response register.
// ----------------------------------------------------------------------------
module tcw_back
   import tcw_pkg::*;
#(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 64,
   parameter int ACOL_W      = 8,
   parameter int AROW_W      = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ACOL_W-1:0] active_cols,
   input  logic [AROW_W-1:0] active_rows,
   input  queue_status_type  queue_status,
   input  cmd_type           head_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata
);

   localparam int COL_W     = $clog2(MAX_COLUMNS);
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int RW1       = ROW_W + 1;
   localparam int ADDR_W    = ROW_W + COL_W;
   localparam int MEM_DEPTH = MAX_ROWS << COL_W;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_SWEEP,
      ST_READ
   } state_type;

   // Screen row to physical row, with the offset wrapping at MAX_ROWS.
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [RW1-1:0]   screen);
      logic [RW1-1:0] sum;
      sum = {1'b0, top} + screen;
      if (sum >= RW1'(MAX_ROWS)) begin
         sum = sum - RW1'(MAX_ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   logic [7:0]          cell_mem [MEM_DEPTH];
   logic [7:0]          mem_rd_data_ff;
   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic [7:0]          mem_wr_data;
   logic                mem_rd_en;
   logic [ADDR_W-1:0]   mem_rd_addr;

   state_type           state_ff;
   state_type           state_in;
   logic [COL_W-1:0]    cur_col_ff;
   logic [COL_W-1:0]    cur_col_in;
   logic [ROW_W-1:0]    cur_row_ff;
   logic [ROW_W-1:0]    cur_row_in;
   logic [ROW_W-1:0]    top_ff;
   logic [ROW_W-1:0]    top_in;
   logic [MAX_ROWS-1:0] row_valid_ff;
   logic [MAX_ROWS-1:0] row_valid_in;
   logic [ROW_W-1:0]    sweep_row_ff;
   logic [ROW_W-1:0]    sweep_row_in;
   logic [COL_W-1:0]    sweep_col_ff;
   logic [COL_W-1:0]    sweep_col_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [7:0]          rsp_read_ff;
   logic [7:0]          rsp_read_in;
   logic [6:0]          rsp_col_ff;
   logic [6:0]          rsp_col_in;
   logic [5:0]          rsp_row_ff;
   logic [5:0]          rsp_row_in;
   logic                rsp_scroll_ff;
   logic                rsp_scroll_in;
   logic                rsp_oor_ff;
   logic                rsp_oor_in;

   logic                out_free;
   logic                go;
   logic [COL_W-1:0]    clamp_col;
   logic [ROW_W-1:0]    clamp_row;
   logic [ROW_W-1:0]    stream_phys;
   logic [ROW_W-1:0]    cmd_phys;
   logic [ROW_W-1:0]    bottom_phys;
   logic [ROW_W-1:0]    top_next;
   logic                col_wraps;
   logic                row_wraps;
   logic                emit;
   logic                emit_scroll;
   logic                emit_oor;
   logic [7:0]          emit_read;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_oor_ff, rsp_scroll_ff, rsp_row_ff, rsp_col_ff, rsp_read_ff};

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign go       = (state_ff == ST_RUN) && queue_status.head_valid && out_free;

   // Cursor clamped to the active size before a streamed byte is handled.
   always_comb begin
      clamp_col = cur_col_ff;
      clamp_row = cur_row_ff;
      if (32'(cur_col_ff) >= 32'(active_cols)) begin
         clamp_col = COL_W'(active_cols - ACOL_W'(1));
      end
      if (32'(cur_row_ff) >= 32'(active_rows)) begin
         clamp_row = ROW_W'(active_rows - AROW_W'(1));
      end
   end

   assign stream_phys = phys_row(top_ff, RW1'(clamp_row));
   assign cmd_phys    = phys_row(top_ff, RW1'(head_cmd.row));
   // The new bottom row after a scroll sits one full screen below the old top.
   assign bottom_phys = phys_row(top_ff, RW1'(active_rows));
   assign top_next    = (top_ff == ROW_W'(MAX_ROWS - 1)) ? '0 : top_ff + 1'b1;
   assign col_wraps   = (32'(clamp_col) + 32'd1) >= 32'(active_cols);
   assign row_wraps   = (32'(clamp_row) + 32'd1) >= 32'(active_rows);

   // Command execution.
   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      top_in       = top_ff;
      row_valid_in = row_valid_ff;
      sweep_row_in = sweep_row_ff;
      sweep_col_in = sweep_col_ff;
      pop          = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = {stream_phys, clamp_col};
      mem_wr_data  = head_cmd.char_byte;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = {cmd_phys, COL_W'(head_cmd.column)};
      emit         = 1'b0;
      emit_scroll  = 1'b0;
      emit_oor     = 1'b0;
      emit_read    = 8'd0;

      case (state_ff)
         ST_RUN: begin
            if (go) begin
               case (head_cmd.kind)
                  KIND_MOVE: begin
                     cur_col_in = COL_W'(head_cmd.column);
                     cur_row_in = ROW_W'(head_cmd.row);
                     pop        = 1'b1;
                     emit       = 1'b1;
                  end
                  KIND_CLEAR: begin
                     // Invalid rows read as zero, so a clear needs no pass over the cells.
                     row_valid_in = '0;
                     cur_col_in   = '0;
                     cur_row_in   = '0;
                     top_in       = '0;
                     pop          = 1'b1;
                     emit         = 1'b1;
                  end
                  KIND_PLACE: begin
                     if (head_cmd.out_of_range) begin
                        emit_oor = 1'b1;
                        pop      = 1'b1;
                        emit     = 1'b1;
                     end else if (!row_valid_ff[cmd_phys]) begin
                        sweep_row_in = cmd_phys;
                        sweep_col_in = '0;
                        state_in     = ST_SWEEP;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = {cmd_phys, COL_W'(head_cmd.column)};
                        pop         = 1'b1;
                        emit        = 1'b1;
                     end
                  end
                  KIND_READ: begin
                     if (head_cmd.out_of_range) begin
                        emit_oor = 1'b1;
                        pop      = 1'b1;
                        emit     = 1'b1;
                     end else if (!row_valid_ff[cmd_phys]) begin
                        pop  = 1'b1;
                        emit = 1'b1;
                     end else begin
                        mem_rd_en = 1'b1;
                        pop       = 1'b1;
                        state_in  = ST_READ;
                     end
                  end
                  KIND_NEWLINE: begin
                     cur_col_in = '0;
                     if (row_wraps) begin
                        cur_row_in                = clamp_row;
                        top_in                    = top_next;
                        row_valid_in[bottom_phys] = 1'b0;
                        emit_scroll               = 1'b1;
                     end else begin
                        cur_row_in = clamp_row + 1'b1;
                     end
                     pop  = 1'b1;
                     emit = 1'b1;
                  end
                  KIND_CHAR: begin
                     if (!row_valid_ff[stream_phys]) begin
                        sweep_row_in = stream_phys;
                        sweep_col_in = '0;
                        state_in     = ST_SWEEP;
                     end else begin
                        mem_wr_en = 1'b1;
                        if (!col_wraps) begin
                           cur_col_in = clamp_col + 1'b1;
                           cur_row_in = clamp_row;
                        end else if (row_wraps) begin
                           cur_col_in                = '0;
                           cur_row_in                = clamp_row;
                           top_in                    = top_next;
                           row_valid_in[bottom_phys] = 1'b0;
                           emit_scroll               = 1'b1;
                        end else begin
                           cur_col_in = '0;
                           cur_row_in = clamp_row + 1'b1;
                        end
                        pop  = 1'b1;
                        emit = 1'b1;
                     end
                  end
                  default: begin
                     pop  = 1'b1;
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            // Zero one cell of the row per cycle, then retry the command.
            mem_wr_en    = 1'b1;
            mem_wr_addr  = {sweep_row_ff, sweep_col_ff};
            mem_wr_data  = 8'd0;
            sweep_col_in = sweep_col_ff + 1'b1;
            if (sweep_col_ff == COL_W'(MAX_COLUMNS - 1)) begin
               row_valid_in[sweep_row_ff] = 1'b1;
               state_in                   = ST_RUN;
            end
         end
         ST_READ: begin
            // The output slot was free when the read was issued.
            emit_read = mem_rd_data_ff;
            emit      = 1'b1;
            state_in  = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      // Response register: hold until taken, load on emit.
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_read_in   = rsp_read_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_scroll_in = rsp_scroll_ff;
      rsp_oor_in    = rsp_oor_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_read_in   = emit_read;
         rsp_col_in    = 7'(cur_col_in);
         rsp_row_in    = 6'(cur_row_in);
         rsp_scroll_in = emit_scroll;
         rsp_oor_in    = emit_oor;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         top_ff       <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         top_ff       <= top_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sweep_row_ff  <= sweep_row_in;
      sweep_col_ff  <= sweep_col_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_scroll_ff <= rsp_scroll_in;
      rsp_oor_ff    <= rsp_oor_in;
   end

   // Cell memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         cell_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         mem_rd_data_ff <= cell_mem[mem_rd_addr];
      end
   end

endmodule

>>> rtl/core/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// Text console writer core
// Character cell store with cursor, wrap at the row end and scroll.
// ----------------------------------------------------------------------------
// Every request beat gives exactly one response beat. Streamed characters run at
// one per cycle while the response side takes them and no row must be zeroed.
// A read goes through the registered read port of the cell memory. Clear and
// scroll need no pass over the cells: each physical row has a valid bit, and a
// row that is not valid reads as zeros. The first write into such a row (after
// reset, a clear or a scroll) first zeroes the row, one cell per cycle, and a
// two-entry command queue lets the request side keep accepting meanwhile. No
// clearing pass follows reset. Write the registers over the csr port only while
// the core is idle; the core itself does not enforce this.
module text_console_writer_core
   import tcw_pkg::*;
#(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 64
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] mode
   input  logic [23:0] req_tdata,   // [7:0] char_byte, [14:8] column, [20:15] row
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] read_data, [14:8] cursor_column,
                                    // [20:15] cursor_row, [21] scrolled,
                                    // [22] out_of_range
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   localparam int ACOL_W = $clog2(MAX_COLUMNS + 1);
   localparam int AROW_W = $clog2(MAX_ROWS + 1);

   logic [7:0]        cols_cfg_ff;
   logic [6:0]        rows_cfg_ff;
   logic [ACOL_W-1:0] active_cols;
   logic [AROW_W-1:0] active_rows;

   queue_status_type  queue_status;
   logic              push;
   cmd_type           push_cmd;
   logic              pop;
   cmd_type           head_cmd;

   // Configuration registers, always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_cfg_ff <= COLUMNS_RESET;
         rows_cfg_ff <= ROWS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COLUMNS: cols_cfg_ff <= csr_data;
            CSR_ROWS:    rows_cfg_ff <= csr_data[6:0];
            default:     cols_cfg_ff <= cols_cfg_ff;
         endcase
      end
   end

   // Active size: zero acts as one, too large acts as the maximum.
   always_comb begin
      if (cols_cfg_ff == '0) begin
         active_cols = ACOL_W'(1);
      end else if ({24'd0, cols_cfg_ff} > MAX_COLUMNS) begin
         active_cols = ACOL_W'(MAX_COLUMNS);
      end else begin
         active_cols = ACOL_W'(cols_cfg_ff);
      end
      if (rows_cfg_ff == '0) begin
         active_rows = AROW_W'(1);
      end else if ({25'd0, rows_cfg_ff} > MAX_ROWS) begin
         active_rows = AROW_W'(MAX_ROWS);
      end else begin
         active_rows = AROW_W'(rows_cfg_ff);
      end
   end

   tcw_front #(
      .ACOL_W (ACOL_W),
      .AROW_W (AROW_W)
   ) u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .active_cols  (active_cols),
      .active_rows  (active_rows),
      .queue_status (queue_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   tcw_cmd_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_cmd     (push_cmd),
      .pop          (pop),
      .queue_status (queue_status),
      .head_cmd     (head_cmd)
   );

   tcw_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .ACOL_W      (ACOL_W),
      .AROW_W      (AROW_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .active_cols  (active_cols),
      .active_rows  (active_rows),
      .queue_status (queue_status),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

>>> rtl/core/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console checker
// Port-level checks on the console core, attached by a bind statement.
// ----------------------------------------------------------------------------
module tcw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic [3:0] pending_ff;
   logic [3:0] pending_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // Items accepted whose response has not been taken yet.
   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 4'd1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled response beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Every response belongs to an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 4'd0)
      else $error("response without a pending request");

   // A scroll always leaves the cursor at the start of a row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |-> rsp_tdata[14:8] == 7'd0)
      else $error("scroll with cursor not in column zero");

   // A position out of range never returns cell data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[22] |-> rsp_tdata[7:0] == 8'd0 && !rsp_tdata[21])
      else $error("out of range response carries data or a scroll");

endmodule

bind text_console_writer_core tcw_checker u_checker (.*);
